[rtl/jpeg2000_component_to_rgba8_unit_macros.svh]
// ----------------------------------------------------------------------------
// jpeg2000_component_to_rgba8_unit_macros.svh
// Assertion helpers shared by the pixel unit.
// ----------------------------------------------------------------------------
`ifndef JPEG2000_COMPONENT_TO_RGBA8_UNIT_MACROS_SVH
`define JPEG2000_COMPONENT_TO_RGBA8_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk, off while in reset.
`define JC2R_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off while in reset.
`define JC2R_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/jc2r_pkg.sv]
// ----------------------------------------------------------------------------
// jc2r_pkg
// Types, register indexes and constants of the component-to-RGBA8 unit.
// ----------------------------------------------------------------------------
package jc2r_pkg;

	localparam int SAMPLE_W    = 32;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;

	// Register indexes of the configuration port
	localparam logic [CFG_INDEX_W-1:0] REG_COMPONENT_COUNT = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_COLOR_MODE      = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PRECISION_ZERO  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_PRECISION_ONE   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_PRECISION_TWO   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_PRECISION_THREE = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_SIGNED_MASK     = 3'd6;

	// Color space codes (anything else is RGB)
	localparam logic [1:0] CS_CMYK = 2'd1;
	localparam logic [1:0] CS_SYCC = 2'd2;

	// BT.601 fixed-point coefficients, scale 1024
	localparam logic signed [11:0] K_CR_RED   = 12'sd1436;
	localparam logic signed [11:0] K_CB_GREEN = 12'sd352;
	localparam logic signed [11:0] K_CR_GREEN = 12'sd731;
	localparam logic signed [11:0] K_CB_BLUE  = 12'sd1815;
	localparam logic signed [8:0]  CHROMA_MID = 9'sd128;
	localparam logic [7:0]         FULL_BYTE  = 8'd255;

	typedef struct packed {
		logic [2:0] component_count;
		logic [1:0] color_mode;
		logic [5:0] precision_zero;
		logic [5:0] precision_one;
		logic [5:0] precision_two;
		logic [5:0] precision_three;
		logic [3:0] signed_mask;
	} cfg_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} pixel_t;

	localparam cfg_t CFG_RESET = '{
		component_count: 3'd3,
		color_mode:      2'd0,
		precision_zero:  6'd8,
		precision_one:   6'd8,
		precision_two:   6'd8,
		precision_three: 6'd8,
		signed_mask:     4'd0
	};

	// Clamp a small signed value to 0..255
	function automatic logic [7:0] clamp_byte(input logic signed [11:0] v);
		logic [7:0] res;
		if (v[11])
			res = 8'd0;
		else if (|v[10:8])
			res = FULL_BYTE;
		else
			res = v[7:0];
		return res;
	endfunction

endpackage

[rtl/jc2r_in_if.sv]
// ----------------------------------------------------------------------------
// jc2r_in_if
// Sample channel: four raw component samples of one pixel.
// ----------------------------------------------------------------------------
interface jc2r_in_if import jc2r_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_zero;
	logic signed [SAMPLE_W-1:0] sample_one;
	logic signed [SAMPLE_W-1:0] sample_two;
	logic signed [SAMPLE_W-1:0] sample_three;

	modport source(output valid, sample_zero, sample_one, sample_two, sample_three,
		input ready);
	modport sink(input valid, sample_zero, sample_one, sample_two, sample_three,
		output ready);
endinterface

[rtl/jc2r_out_if.sv]
// ----------------------------------------------------------------------------
// jc2r_out_if
// Pixel channel: one RGBA8 pixel.
// ----------------------------------------------------------------------------
interface jc2r_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;

	modport source(output valid, red, green, blue, alpha, input ready);
	modport sink(input valid, red, green, blue, alpha, output ready);
endinterface

[rtl/jc2r_cfg_if.sv]
// ----------------------------------------------------------------------------
// jc2r_cfg_if
// Register write channel: index and data.
// ----------------------------------------------------------------------------
interface jc2r_cfg_if import jc2r_pkg::*;;
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[rtl/jc2r_norm.sv]
// ----------------------------------------------------------------------------
// jc2r_norm
// Normalizes one raw sample to 8 bits: signed bias, shift, clamp.
// ----------------------------------------------------------------------------
module jc2r_norm import jc2r_pkg::*; (
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic [5:0]                 prec,
	input  logic                       sgn,
	output logic [7:0]                 byte_out
);

	always_comb begin
		logic signed [32:0] biased;
		logic signed [40:0] wide;
		logic [4:0]         rsh;
		logic [2:0]         lsh;

		// Half-range bias for signed samples below 31 bits
		biased = {sample[SAMPLE_W-1], sample};
		if (sgn && prec < 6'd31 && prec != 6'd0)
			biased = biased + (33'sd1 <<< (prec - 6'd1));

		// Shift toward 8 bits (floor on the right shift)
		rsh  = 5'(prec - 6'd8);
		lsh  = 3'(6'd8 - prec);
		wide = {{8{biased[32]}}, biased};
		if (prec > 6'd8)
			wide = wide >>> rsh;
		else if (prec < 6'd8)
			wide = wide <<< lsh;

		// Clamp; out-of-range precision gives zero
		if (prec == 6'd0 || prec > 6'd32)
			byte_out = 8'd0;
		else if (wide[40])
			byte_out = 8'd0;
		else if (|wide[39:8])
			byte_out = FULL_BYTE;
		else
			byte_out = wide[7:0];
	end

endmodule

[rtl/jc2r_convert.sv]
// ----------------------------------------------------------------------------
// jc2r_convert
// Mode select: grey, grey plus alpha, CMYK, sYCC (BT.601) or RGB.
// ----------------------------------------------------------------------------
module jc2r_convert import jc2r_pkg::*; (
	input  cfg_t       cfg,
	input  logic [7:0] s0,
	input  logic [7:0] s1,
	input  logic [7:0] s2,
	input  logic [7:0] s3,
	output pixel_t     pix
);

	logic               four;
	logic [7:0]         kinv;
	logic [15:0]        pc, pm, py;
	logic [7:0]         cr, cm, cy;
	logic signed [8:0]  cbd, crd;
	logic signed [19:0] pr, pb;
	logic signed [20:0] pg;
	logic signed [11:0] yr, yg, yb;

	assign four = cfg.component_count >= 3'd4;

	// CMYK: floor(p / 255) as ((p + 1) + ((p + 1) >> 8)) >> 8
	function automatic logic [7:0] div255(input logic [15:0] p);
		logic [16:0] t;
		logic [17:0] u;
		t = {1'b0, p} + 17'd1;
		u = {1'b0, t} + {9'd0, t[16:8]};
		return u[15:8];
	endfunction

	assign kinv = four ? (FULL_BYTE - s3) : FULL_BYTE;
	assign pc   = (FULL_BYTE - s0) * kinv;
	assign pm   = (FULL_BYTE - s1) * kinv;
	assign py   = (FULL_BYTE - s2) * kinv;
	assign cr   = div255(pc);
	assign cm   = div255(pm);
	assign cy   = div255(py);

	// sYCC: chroma offsets, products, floor shift by 10
	assign cbd = $signed({1'b0, s1}) - CHROMA_MID;
	assign crd = $signed({1'b0, s2}) - CHROMA_MID;
	assign pr  = crd * K_CR_RED;
	assign pb  = cbd * K_CB_BLUE;
	assign pg  = cbd * K_CB_GREEN + crd * K_CR_GREEN;
	assign yr  = $signed({4'd0, s0}) + 12'(pr >>> 10);
	assign yg  = $signed({4'd0, s0}) - 12'(pg >>> 10);
	assign yb  = $signed({4'd0, s0}) + 12'(pb >>> 10);

	// Mode select
	always_comb begin
		pix.alpha = FULL_BYTE;
		if (cfg.component_count <= 3'd1) begin
			pix.red   = s0;
			pix.green = s0;
			pix.blue  = s0;
		end else if (cfg.component_count == 3'd2) begin
			pix.red   = s0;
			pix.green = s0;
			pix.blue  = s0;
			pix.alpha = s1;
		end else if (cfg.color_mode == CS_CMYK) begin
			pix.red   = cr;
			pix.green = cm;
			pix.blue  = cy;
		end else if (cfg.color_mode == CS_SYCC) begin
			pix.red   = clamp_byte(yr);
			pix.green = clamp_byte(yg);
			pix.blue  = clamp_byte(yb);
			if (four)
				pix.alpha = s3;
		end else begin
			pix.red   = s0;
			pix.green = s1;
			pix.blue  = s2;
			if (four)
				pix.alpha = s3;
		end
	end

endmodule

[rtl/jpeg2000_component_to_rgba8_unit.sv]
// ----------------------------------------------------------------------------
// jpeg2000_component_to_rgba8_unit
// Turns four raw component samples of a pixel into one RGBA8 pixel.
// ----------------------------------------------------------------------------
// Usage:
//   pixel_in  takes one request of four 32-bit samples; pixel_out gives one
//   RGBA8 pixel per request, in order. cfg writes the seven registers
//   (component count, color space, four precisions, signed mask) by index;
//   it is always ready; the user must write it only while no pixel is in
//   flight, which the block itself does not enforce. Pipeline: a request
//   passes the input, normalized-byte and output registers before
//   pixel_out.valid rises. Throughput: one pixel per cycle while
//   pixel_out.ready is high; each stage holds one pixel.
// Reset: arst_n clears all stage valid flags and loads the register
//   defaults (three components, RGB, 8-bit precision, unsigned).
// Stall: when pixel_out.ready is low the output holds; the stages behind it
//   keep filling, and pixel_in.ready drops only once all three are full.
// ----------------------------------------------------------------------------
`include "jpeg2000_component_to_rgba8_unit_macros.svh"

module jpeg2000_component_to_rgba8_unit import jc2r_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	jc2r_cfg_if.sink      cfg,
	jc2r_in_if.sink       pixel_in,
	jc2r_out_if.source    pixel_out
);

	cfg_t                       cfg_q;
	logic                       v_s1, v_s2, v_s3;
	logic                       en_s1, en_s2, en_s3;
	logic signed [SAMPLE_W-1:0] smp_s1 [4];
	logic [7:0]                 nrm [4];
	logic [7:0]                 nrm_s2 [4];
	pixel_t                     pix;
	pixel_t                     pix_s3;

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_COMPONENT_COUNT: cfg_q.component_count <= cfg.data[2:0];
				REG_COLOR_MODE:      cfg_q.color_mode      <= cfg.data[1:0];
				REG_PRECISION_ZERO:  cfg_q.precision_zero  <= cfg.data[5:0];
				REG_PRECISION_ONE:   cfg_q.precision_one   <= cfg.data[5:0];
				REG_PRECISION_TWO:   cfg_q.precision_two   <= cfg.data[5:0];
				REG_PRECISION_THREE: cfg_q.precision_three <= cfg.data[5:0];
				REG_SIGNED_MASK:     cfg_q.signed_mask     <= cfg.data[3:0];
				default: ;
			endcase
		end
	end

	// Stage advance: a stage loads when empty or when it drains forward
	assign en_s3          = !v_s3 || pixel_out.ready;
	assign en_s2          = !v_s2 || en_s3;
	assign en_s1          = !v_s1 || en_s2;
	assign pixel_in.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1)
				v_s1 <= pixel_in.valid;
			if (en_s2)
				v_s2 <= v_s1;
			if (en_s3)
				v_s3 <= v_s2;
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (en_s1 && pixel_in.valid) begin
			smp_s1[0] <= pixel_in.sample_zero;
			smp_s1[1] <= pixel_in.sample_one;
			smp_s1[2] <= pixel_in.sample_two;
			smp_s1[3] <= pixel_in.sample_three;
		end
	end

	// Per-component normalization
	jc2r_norm u_norm0 (
		.sample(smp_s1[0]), .prec(cfg_q.precision_zero),
		.sgn(cfg_q.signed_mask[0]), .byte_out(nrm[0])
	);
	jc2r_norm u_norm1 (
		.sample(smp_s1[1]), .prec(cfg_q.precision_one),
		.sgn(cfg_q.signed_mask[1]), .byte_out(nrm[1])
	);
	jc2r_norm u_norm2 (
		.sample(smp_s1[2]), .prec(cfg_q.precision_two),
		.sgn(cfg_q.signed_mask[2]), .byte_out(nrm[2])
	);
	jc2r_norm u_norm3 (
		.sample(smp_s1[3]), .prec(cfg_q.precision_three),
		.sgn(cfg_q.signed_mask[3]), .byte_out(nrm[3])
	);

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1)
			nrm_s2 <= nrm;
	end

	// Color conversion and output register
	jc2r_convert u_convert (
		.cfg(cfg_q),
		.s0(nrm_s2[0]),
		.s1(nrm_s2[1]),
		.s2(nrm_s2[2]),
		.s3(nrm_s2[3]),
		.pix(pix)
	);

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2)
			pix_s3 <= pix;
	end

	assign pixel_out.valid = v_s3;
	assign pixel_out.red   = pix_s3.red;
	assign pixel_out.green = pix_s3.green;
	assign pixel_out.blue  = pix_s3.blue;
	assign pixel_out.alpha = pix_s3.alpha;

	// Checks
	`JC2R_ASSERT_NOW(a_ready_when_empty, !v_s1, pixel_in.ready, "input stage empty but not ready")
	`JC2R_ASSERT_NEXT(a_s1_moves_on, v_s1 && en_s2, v_s2, "pixel lost between stage 1 and 2")
	`JC2R_ASSERT_NEXT(a_s2_holds, v_s2 && !en_s3, v_s2, "stalled pixel dropped from stage 2")

endmodule
